// File: hw/rtl/gb3_pkg.sv
// gb3_pkg: types, register indexes and the kernel function for the 3x3 blur.
// Used by gb3_line_mem and gaussian_blur_3x3_rgb; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gb3_pkg;

    localparam int PIX_W  = 24;
    localparam int LINE_W = 2 * PIX_W;
    localparam int CFG_W  = 11;
    localparam int POS_W  = 10;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
    } pix_out_t;

    // rows: a = two above, b = one above, c = current; 1 2 1 / 2 4 2 / 1 2 1
    function automatic logic [7:0] blur_chan(
        input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2,
        input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
        input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2
    );
        logic [11:0] s;
        s = {4'd0, a0} + {3'd0, a1, 1'b0} + {4'd0, a2}
          + {3'd0, b0, 1'b0} + {2'd0, b1, 2'b0} + {3'd0, b2, 1'b0}
          + {4'd0, c0} + {3'd0, c1, 1'b0} + {4'd0, c2};
        return s[11:4];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gaussian_blur_3x3_rgb.sv
// Streaming 3x3 Gaussian blur of RGB pixels in raster order.
// Throughput: one item per cycle unless the output stalls, set by the line memory read-modify-write.
// Result: the result for pixel (r,c) is computed as pixel (r+1,c+1) leaves stage 1, then held in the output register.
// Reset: position, window and output valid cleared, frame size 640 x 480.
// The line memory is not cleared; rows 0 and 1 of each frame fill it before it is used.
// Depends on gb3_pkg and gb3_line_mem.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire gb3_pkg::pix_in_t          in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output gb3_pkg::pix_out_t              out_data,
    input  wire logic                      cfg_we,
    input  wire gb3_pkg::cfg_index_t       cfg_index,
    input  wire logic [gb3_pkg::CFG_W-1:0] cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SZA  = $clog2(MAX_WIDTH + 1);
    localparam int SZB  = $clog2(MAX_HEIGHT + 1);
    localparam int SZ0  = (SZA > SZB) ? SZA : SZB;
    localparam int SZW  = (SZ0 > gb3_pkg::CFG_W) ? SZ0 : gb3_pkg::CFG_W;
    localparam int PW   = gb3_pkg::PIX_W;
    localparam int POSW = gb3_pkg::POS_W;

    // configuration
    logic [gb3_pkg::CFG_W-1:0] frame_width_reg;
    logic [gb3_pkg::CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= gb3_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= gb3_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gb3_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                gb3_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [SZW-1:0] fw_ext;
    logic [SZW-1:0] fh_ext;
    logic [SZW-1:0] eff_w;
    logic [SZW-1:0] eff_h;

    always_comb
    begin
        fw_ext = SZW'(frame_width_reg);
        fh_ext = SZW'(frame_height_reg);
        if (fw_ext < SZW'(3))
            eff_w = SZW'(3);
        else if (fw_ext > SZW'(MAX_WIDTH))
            eff_w = SZW'(MAX_WIDTH);
        else
            eff_w = fw_ext;
        if (fh_ext < SZW'(3))
            eff_h = SZW'(3);
        else if (fh_ext > SZW'(MAX_HEIGHT))
            eff_h = SZW'(MAX_HEIGHT);
        else
            eff_h = fh_ext;
    end

    // position and accept stage
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic          accept;
    logic          in_active;
    logic          in_emit;
    logic [SZW-1:0] col_ext, row_ext, col_inc, row_inc;

    logic            s1_valid_reg;
    logic            s1_active_reg;
    logic            s1_emit_reg;
    logic [CW-1:0]   s1_addr_reg;
    logic [PW-1:0]   s1_cur_reg;
    logic [POSW-1:0] s1_row_reg;
    logic [POSW-1:0] s1_col_reg;
    logic            s1_advance;
    logic            out_free;

    logic                        out_valid_reg;
    gb3_pkg::pix_out_t           out_data_reg;
    gb3_pkg::pix_out_t           out_data_next;
    logic [gb3_pkg::LINE_W-1:0]  rd_data;
    logic [PW-1:0]               top_px, mid_px;
    logic [PW-1:0]               win_reg [6];
    logic                        mem_we;

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!s1_emit_reg || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        col_ext   = SZW'(col_count_reg);
        row_ext   = SZW'(row_count_reg);
        in_active = (col_ext < eff_w) && (row_ext < eff_h);
        in_emit   = in_active && (col_ext >= SZW'(2)) && (row_ext >= SZW'(2));
        col_inc   = col_ext + SZW'(1);
        row_inc   = row_ext + SZW'(1);
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (col_inc >= eff_w)
        begin
            col_count_next = '0;
            if (row_inc >= eff_h)
                row_count_next = '0;
            else
                row_count_next = RW'(row_inc);
        end
        else
        begin
            col_count_next = CW'(col_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_active_reg <= 1'b0;
            s1_emit_reg   <= 1'b0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= 1'b1;
            s1_active_reg <= in_active;
            s1_emit_reg   <= in_emit;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= col_count_reg;
            s1_cur_reg  <= {in_data.blue_in, in_data.green_in, in_data.red_in};
            s1_row_reg  <= POSW'(row_ext - SZW'(1));
            s1_col_reg  <= POSW'(col_ext - SZW'(1));
        end
    end

    // line memory: read at accept, write back {mid, cur} as the item leaves stage 1
    assign mem_we = s1_advance && s1_active_reg;

    gb3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (s1_addr_reg),
        .wdata ({mid_px, s1_cur_reg}),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (rd_data)
    );

    assign top_px = rd_data[gb3_pkg::LINE_W-1:PW];
    assign mid_px = rd_data[PW-1:0];

    // window: 0..2 left column (top, mid, bottom), 3..5 two to the left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (mem_we)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top_px;
            win_reg[1] <= mid_px;
            win_reg[2] <= s1_cur_reg;
        end
    end

    always_comb
    begin
        out_data_next.red_out = gb3_pkg::blur_chan(
            win_reg[3][7:0], win_reg[0][7:0], top_px[7:0],
            win_reg[4][7:0], win_reg[1][7:0], mid_px[7:0],
            win_reg[5][7:0], win_reg[2][7:0], s1_cur_reg[7:0]);
        out_data_next.green_out = gb3_pkg::blur_chan(
            win_reg[3][15:8], win_reg[0][15:8], top_px[15:8],
            win_reg[4][15:8], win_reg[1][15:8], mid_px[15:8],
            win_reg[5][15:8], win_reg[2][15:8], s1_cur_reg[15:8]);
        out_data_next.blue_out = gb3_pkg::blur_chan(
            win_reg[3][23:16], win_reg[0][23:16], top_px[23:16],
            win_reg[4][23:16], win_reg[1][23:16], mid_px[23:16],
            win_reg[5][23:16], win_reg[2][23:16], s1_cur_reg[23:16]);
        out_data_next.center_row = s1_row_reg;
        out_data_next.center_col = s1_col_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_emit_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // consecutive items always touch different columns, so no read-during-write
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && accept) |-> (s1_addr_reg != col_count_reg))
        else $error("line memory read and write hit the same entry");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_emit_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_emit_reg) |=> out_valid_reg)
        else $error("result left stage 1 but output register is empty");

endmodule

`default_nettype wire

// File: hw/rtl/gb3_line_mem.sv
// gb3_line_mem: two-row line store, one write and one registered read port.
// Each word holds {pixel two rows above, pixel one row above}; uses gb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb3_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [gb3_pkg::LINE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [gb3_pkg::LINE_W-1:0] rdata
);

    logic [gb3_pkg::LINE_W-1:0] mem [DEPTH];
    logic [gb3_pkg::LINE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
